// ----- design/ctab_pkg.sv -----
// Shared types and codes for the time advance barrier.
package ctab_pkg;

  localparam int TIME_W = 63;

  localparam logic [1:0] MODE_REG   = 2'd0;
  localparam logic [1:0] MODE_UNREG = 2'd1;
  localparam logic [1:0] MODE_ADV   = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_GRANT  = 2'd2;

  localparam logic [3:0] MAX_GRANTS = 4'd8;

  // Command broadcast to every cell on the accept cycle
  typedef struct packed {
    logic              load;
    logic [1:0]        mode;
    logic [TIME_W-1:0] req_time;
    logic              any_active;
  } cmd_t;

  // Per-cell status seen by the command decision
  typedef struct packed {
    logic active;
    logic adv_ok;
  } cell_stat_t;

  // Minimum-search token passed along the chain
  typedef struct packed {
    logic              valid;
    logic              any;
    logic              all;
    logic [TIME_W-1:0] least;
  } token_t;

endpackage

// ----- design/ctab_cell.sv -----
// One client cell: active flag, shifting request queue and a stage of the min chain.
module ctab_cell #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctab_pkg::cmd_t                 cmd,
  input  logic                           sel,
  input  logic [ctab_pkg::TIME_W-1:0]    now_time,
  input  logic                           drop_en,
  input  ctab_pkg::token_t               tok_in,
  output ctab_pkg::token_t               tok_out,
  output ctab_pkg::cell_stat_t           stat,
  output logic                           drop_req
);
  import ctab_pkg::*;

  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic              active;
  logic [CNTW-1:0]   count;
  logic [TIME_W-1:0] q [QUEUE_DEPTH];
  logic [TIME_W-1:0] tail_time;

  logic [CNTW-1:0]   cnt_eff;
  logic [TIME_W-1:0] bound;
  logic              full;
  token_t            tok_next;

  // Acceptance of an advance request against this queue
  always_comb begin
    cnt_eff  = active ? count : '0;
    bound    = (cnt_eff == '0) ? now_time : tail_time;
    full     = (cnt_eff == CNTW'(QUEUE_DEPTH));
    stat.active = active;
    stat.adv_ok = (cmd.req_time > bound) && !full;
    drop_req = active && (count != '0) && (q[0] <= now_time);
  end

  // Update flag and queue from commands and drops
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count  <= '0;
    end else if (cmd.load) begin
      if (cmd.mode == MODE_CLEAR) begin
        count <= '0;
      end else if (sel) begin
        case (cmd.mode)
          MODE_REG: begin
            if (!active) begin
              active <= 1'b1;
              count  <= '0;
            end
          end
          MODE_UNREG: begin
            if (active) begin
              active <= 1'b0;
              count  <= '0;
            end
          end
          MODE_ADV: begin
            if (cmd.any_active) begin
              active <= 1'b1;
              if (stat.adv_ok) begin
                count <= cnt_eff + 1'b1;
              end else begin
                count <= cnt_eff;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else if (drop_en && drop_req) begin
      count <= count - 1'b1;
    end
  end

  // Queue payload: write at the tail, shift toward the head on a drop
  always_ff @(posedge clk) begin
    if (cmd.load && sel && cmd.mode == MODE_ADV && cmd.any_active && stat.adv_ok) begin
      q[cnt_eff[IW-1:0]] <= cmd.req_time;
      tail_time          <= cmd.req_time;
    end else if (!cmd.load && drop_en && drop_req) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        q[k] <= q[k+1];
      end
    end
  end

  // Fold this queue head into the passing token
  always_comb begin
    tok_next = tok_in;
    if (active) begin
      if (count == '0) begin
        tok_next.all = 1'b0;
      end else begin
        tok_next.any = 1'b1;
        if (!tok_in.any || q[0] < tok_in.least) begin
          tok_next.least = q[0];
        end
      end
    end
  end

  // Advance the token one stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.any   <= tok_next.any;
    tok_out.all   <= tok_next.all;
    tok_out.least <= tok_next.least;
  end

endmodule

// ----- design/conservative_time_advance_barrier.sv -----
// Top level of the conservative time advance barrier: sequencer and cell chain.
//
//   channel  direction  handshake            words
//   in       sink       in_valid/in_ready    mode, client, req_time
//   out      source     out_valid/out_ready  kind, granted_time, last
//
// One command at a time; in_ready is high only while idle. A command without a
// scan goes straight to the push step. A scan runs up to 8 rounds, each of a
// queue drop pass, a walk of the token along the cell chain and a push of a
// result; a final drop pass closes the scan. Output stalls hold the sequencer
// in its push step.
// Synchronous active-high reset empties all queues, clears flags and time.
module conservative_time_advance_barrier #(
  parameter int NUM_CLIENTS = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [2:0]                  client,
  input  logic [ctab_pkg::TIME_W-1:0] req_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic [ctab_pkg::TIME_W-1:0] granted_time,
  output logic                        last
);
  import ctab_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DROP = 2'd1;
  localparam logic [1:0] S_MIN  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]        state;
  logic [TIME_W-1:0] now_time;
  logic [1:0]        pend_kind;
  logic [TIME_W-1:0] pend_time;
  logic [TIME_W-1:0] least_r;
  logic [3:0]        grants;
  logic              final_pass;
  logic              push_last;

  cmd_t              cmd;
  logic              drop_en;
  logic              accept;
  logic              in_range;
  logic              any_active;
  logic              drop_any;
  logic              ok;
  logic              do_scan;
  logic              out_free;
  logic              push_fire;
  cell_stat_t        sel_stat;
  logic [NUM_CLIENTS-1:0] sel;
  logic [NUM_CLIENTS-1:0] act_v;
  logic [NUM_CLIENTS-1:0] drop_v;
  cell_stat_t        stat_v [NUM_CLIENTS];
  token_t            tok [NUM_CLIENTS+1];

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign drop_en   = (state == S_DROP);
  assign out_free  = !out_valid || out_ready;
  assign push_fire = (state == S_PUSH) && out_free;
  assign in_range  = ({4'd0, client} < 7'(NUM_CLIENTS));

  // Select the addressed cell and gather flags
  always_comb begin
    sel_stat = '0;
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      sel[i] = in_range && (i < 8) && (client == 3'(i));
      if (sel[i]) begin
        sel_stat = stat_v[i];
      end
      act_v[i] = stat_v[i].active;
    end
    any_active = |act_v;
    drop_any   = |drop_v;
  end

  // Decide the command result
  always_comb begin
    ok      = 1'b0;
    do_scan = 1'b0;
    case (mode)
      MODE_REG:   ok = in_range && !sel_stat.active;
      MODE_UNREG: begin
        ok      = in_range && sel_stat.active;
        do_scan = ok;
      end
      MODE_ADV: begin
        ok      = in_range && any_active && sel_stat.adv_ok;
        do_scan = ok;
      end
      default:    ok = 1'b1;
    endcase
  end

  always_comb begin
    cmd.load       = accept;
    cmd.mode       = mode;
    cmd.req_time   = req_time;
    cmd.any_active = any_active;
  end

  // Launch a token into the chain once a drop pass settles
  always_comb begin
    tok[0].valid = drop_en && !drop_any && !final_pass && (grants != MAX_GRANTS);
    tok[0].any   = 1'b0;
    tok[0].all   = 1'b1;
    tok[0].least = '0;
  end

  for (genvar g = 0; g < NUM_CLIENTS; g++) begin : g_cell
    ctab_cell #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel[g]),
      .now_time (now_time),
      .drop_en  (drop_en),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1]),
      .stat     (stat_v[g]),
      .drop_req (drop_v[g])
    );
  end

  // Sequence the scan and hand words to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_time   <= '0;
      grants     <= '0;
      final_pass <= 1'b0;
      push_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_kind  <= ok ? KIND_ACCEPT : KIND_REJECT;
            pend_time  <= (mode == MODE_CLEAR) ? '0 : now_time;
            grants     <= '0;
            final_pass <= 1'b0;
            if (mode == MODE_CLEAR) begin
              now_time <= '0;
            end
            if (do_scan) begin
              state <= S_DROP;
            end else begin
              push_last <= 1'b1;
              state     <= S_PUSH;
            end
          end
        end
        S_DROP: begin
          if (!drop_any) begin
            if (final_pass || grants == MAX_GRANTS) begin
              push_last <= 1'b1;
              state     <= S_PUSH;
            end else begin
              state <= S_MIN;
            end
          end
        end
        S_MIN: begin
          if (tok[NUM_CLIENTS].valid) begin
            if (tok[NUM_CLIENTS].any && tok[NUM_CLIENTS].all) begin
              least_r   <= tok[NUM_CLIENTS].least;
              push_last <= 1'b0;
              state     <= S_PUSH;
            end else begin
              final_pass <= 1'b1;
              state      <= S_DROP;
            end
          end
        end
        default: begin
          if (out_free) begin
            kind         <= pend_kind;
            granted_time <= pend_time;
            last         <= push_last;
            if (push_last) begin
              state <= S_IDLE;
            end else begin
              pend_kind <= KIND_GRANT;
              pend_time <= least_r;
              now_time  <= least_r;
              grants    <= grants + 1'b1;
              state     <= S_DROP;
            end
          end
        end
      endcase
    end
  end

endmodule
